// File: rtl/core/tfdx_pkg.sv
// shared types, codes and constants of the typed frame deframer
`default_nettype none

package tfdx_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'h41;
    localparam logic [7:0]  TYPE_LONG     = 8'h5A;
    localparam logic [7:0]  TYPE_MID      = 8'h59;
    localparam logic [7:0]  TYPE_SHORT    = 8'h58;
    localparam logic [5:0]  LEN_LONG      = 6'd34;
    localparam logic [5:0]  LEN_MID       = 6'd24;
    localparam logic [5:0]  LEN_SHORT     = 6'd14;
    localparam logic [5:0]  LEN_NONE      = 6'd0;
    localparam logic [5:0]  POS_SYNC      = 6'd0;
    localparam logic [5:0]  POS_TYPE      = 6'd1;
    localparam logic [5:0]  POS_FIRST_DAT = 6'd2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_GOOD    = 3'd1,
        ST_BADSUM  = 3'd2,
        ST_BADTYPE = 3'd3,
        ST_TIMEOUT = 3'd4
    } t_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] position;
        logic       last;
        t_status    frame_status;
    } t_result;

    function automatic logic [5:0] type_length(input logic [7:0] type_byte);
        logic [5:0] len;
        len = LEN_NONE;
        if (type_byte == TYPE_LONG) begin
            len = LEN_LONG;
        end else if (type_byte == TYPE_MID) begin
            len = LEN_MID;
        end else if (type_byte == TYPE_SHORT) begin
            len = LEN_SHORT;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/typed_frame_deframer_xor_unit.sv
// top level of the typed frame deframer with xor checksum
// two register stages: an accepted item is held in the input register, its result in the output register
// one item per cycle while the output is not stalled, with the single core pass between two registers
// items that cause no result (hunting bytes, ticks below the limit) leave no output
// reset (synchronous, active low): hunting for sync, timeout limit 2000 ticks
// the config port is always ready; write only while no item is in flight
`default_nettype none

module typed_frame_deframer_xor_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_in_kind,
    input  wire logic [7:0]  i_in_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_frame_byte,
    output logic [5:0]       o_out_position,
    output logic             o_out_last,
    output logic [2:0]       o_out_frame_status
);

    tfdx_pkg::t_item   in_item;
    tfdx_pkg::t_item   s1_item;
    logic              s1_valid;
    logic              s2_ready;
    logic              fire;
    logic              res_valid;
    tfdx_pkg::t_result res;
    tfdx_pkg::t_result out_res;

    assign o_cfg_ready     = 1'b1;
    assign in_item.kind    = i_in_kind;
    assign in_item.rx_byte = i_in_rx_byte;
    assign fire            = s1_valid && s2_ready;

    tfdx_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_item       (in_item),
        .o_in_stall   (o_in_stall),
        .i_down_ready (s2_ready),
        .o_valid      (s1_valid),
        .o_item       (s1_item)
    );

    tfdx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (s1_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tfdx_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire && res_valid),
        .i_res       (res),
        .o_ready     (s2_ready),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_out_frame_byte   = out_res.frame_byte;
    assign o_out_position     = out_res.position;
    assign o_out_last         = out_res.last;
    assign o_out_frame_status = out_res.frame_status;

endmodule

`default_nettype wire

// File: rtl/core/tfdx_in_reg.sv
// input register stage holding one accepted item
`default_nettype none

module tfdx_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire tfdx_pkg::t_item i_item,
    output logic                 o_in_stall,
    input  wire logic            i_down_ready,
    output logic                 o_valid,
    output tfdx_pkg::t_item      o_item
);

    logic            r_valid;
    logic            n_valid;
    tfdx_pkg::t_item r_item;
    logic            accept;

    assign o_in_stall = r_valid && !i_down_ready;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_down_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: rtl/core/tfdx_core.sv
// frame state machine, xor check, tick timeout and config register
`default_nettype none

module tfdx_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic            i_fire,
    input  wire tfdx_pkg::t_item i_item,
    output logic                 o_res_valid,
    output tfdx_pkg::t_result    o_res
);

    tfdx_pkg::t_phase r_phase;
    tfdx_pkg::t_phase n_phase;
    logic [5:0]       r_idx;
    logic [5:0]       n_idx;
    logic [5:0]       r_len;
    logic [5:0]       n_len;
    logic [7:0]       r_xor;
    logic [7:0]       n_xor;
    logic [15:0]      r_elapsed;
    logic [15:0]      n_elapsed;
    logic [15:0]      r_timeout;

    logic [16:0]      ticks_next;
    logic             timeout_hit;
    logic [5:0]       type_len;
    logic             last_byte;
    logic             is_tick;
    logic [7:0]       b;

    assign is_tick     = (i_item.kind == tfdx_pkg::KIND_TICK);
    assign b           = i_item.rx_byte;
    assign ticks_next  = {1'b0, r_elapsed} + 17'd1;
    assign timeout_hit = ticks_next > {1'b0, r_timeout};
    assign type_len    = tfdx_pkg::type_length(b);
    assign last_byte   = ({1'b0, r_idx} + 7'd1) >= {1'b0, r_len};

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            tfdx_pkg::PH_TYPE: begin
                if (is_tick) begin
                    n_phase = timeout_hit ? tfdx_pkg::PH_HUNT : tfdx_pkg::PH_TYPE;
                end else begin
                    n_phase = (type_len == tfdx_pkg::LEN_NONE) ? tfdx_pkg::PH_HUNT
                                                               : tfdx_pkg::PH_DATA;
                end
            end
            tfdx_pkg::PH_DATA: begin
                if (is_tick) begin
                    n_phase = timeout_hit ? tfdx_pkg::PH_HUNT : tfdx_pkg::PH_DATA;
                end else begin
                    n_phase = last_byte ? tfdx_pkg::PH_HUNT : tfdx_pkg::PH_DATA;
                end
            end
            default: begin
                n_phase = (!is_tick && b == tfdx_pkg::SYNC_BYTE) ? tfdx_pkg::PH_TYPE
                                                                 : tfdx_pkg::PH_HUNT;
            end
        endcase
    end

    // result and datapath
    always_comb begin
        n_idx             = r_idx;
        n_len             = r_len;
        n_xor             = r_xor;
        n_elapsed         = r_elapsed;
        o_res_valid       = 1'b0;
        o_res.frame_byte  = b;
        o_res.position    = r_idx;
        o_res.last        = 1'b0;
        o_res.frame_status = tfdx_pkg::ST_BUSY;
        case (r_phase)
            tfdx_pkg::PH_TYPE, tfdx_pkg::PH_DATA: begin
                if (is_tick) begin
                    if (timeout_hit) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_byte   = 8'd0;
                        o_res.last         = 1'b1;
                        o_res.frame_status = tfdx_pkg::ST_TIMEOUT;
                        n_idx              = 6'd0;
                        n_len              = tfdx_pkg::LEN_NONE;
                        n_xor              = 8'd0;
                        n_elapsed          = 16'd0;
                    end else begin
                        n_elapsed = ticks_next[15:0];
                    end
                end else if (r_phase == tfdx_pkg::PH_TYPE) begin
                    o_res_valid    = 1'b1;
                    o_res.position = tfdx_pkg::POS_TYPE;
                    if (type_len == tfdx_pkg::LEN_NONE) begin
                        o_res.last         = 1'b1;
                        o_res.frame_status = tfdx_pkg::ST_BADTYPE;
                        n_idx              = 6'd0;
                        n_len              = tfdx_pkg::LEN_NONE;
                        n_xor              = 8'd0;
                        n_elapsed          = 16'd0;
                    end else begin
                        n_len = type_len;
                        n_xor = r_xor ^ b;
                        n_idx = tfdx_pkg::POS_FIRST_DAT;
                    end
                end else begin
                    o_res_valid = 1'b1;
                    if (last_byte) begin
                        o_res.last         = 1'b1;
                        o_res.frame_status = (r_xor == b) ? tfdx_pkg::ST_GOOD
                                                          : tfdx_pkg::ST_BADSUM;
                        n_idx              = 6'd0;
                        n_len              = tfdx_pkg::LEN_NONE;
                        n_xor              = 8'd0;
                        n_elapsed          = 16'd0;
                    end else begin
                        n_xor = r_xor ^ b;
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            default: begin
                if (!is_tick && b == tfdx_pkg::SYNC_BYTE) begin
                    o_res_valid    = 1'b1;
                    o_res.position = tfdx_pkg::POS_SYNC;
                    n_idx          = tfdx_pkg::POS_TYPE;
                    n_len          = tfdx_pkg::LEN_NONE;
                    n_xor          = tfdx_pkg::SYNC_BYTE;
                    n_elapsed      = 16'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= tfdx_pkg::PH_HUNT;
            r_idx     <= 6'd0;
            r_len     <= tfdx_pkg::LEN_NONE;
            r_xor     <= 8'd0;
            r_elapsed <= 16'd0;
            r_timeout <= tfdx_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_fire) begin
                r_phase   <= n_phase;
                r_idx     <= n_idx;
                r_len     <= n_len;
                r_xor     <= n_xor;
                r_elapsed <= n_elapsed;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tfdx_out_reg.sv
// result register stage toward the output channel
`default_nettype none

module tfdx_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire tfdx_pkg::t_result i_res,
    output logic                   o_ready,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output tfdx_pkg::t_result      o_res
);

    logic              r_valid;
    logic              n_valid;
    tfdx_pkg::t_result r_res;

    assign o_ready = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// File: rtl/core/tfdx_checker.sv
// port-level checker for the deframer and its bind to the top level
`default_nettype none

module tfdx_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_out_frame_byte,
    input wire logic [5:0]  o_out_position,
    input wire logic        o_out_last,
    input wire logic [2:0]  o_out_frame_status
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_out_frame_byte) && $stable(o_out_position)
            && $stable(o_out_last) && $stable(o_out_frame_status))
        else $error("stalled result item changed");

    // last and a final status go together
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_last == (o_out_frame_status != tfdx_pkg::ST_BUSY)))
        else $error("last flag disagrees with frame status");

    // a bad type is always reported at the type position
    a_badtype_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_frame_status == tfdx_pkg::ST_BADTYPE
            |-> o_out_position == tfdx_pkg::POS_TYPE)
        else $error("bad type reported off the type position");

    // a timeout carries no byte and never lands at the sync position
    a_timeout_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_frame_status == tfdx_pkg::ST_TIMEOUT
            |-> o_out_frame_byte == 8'd0 && o_out_position != tfdx_pkg::POS_SYNC)
        else $error("malformed timeout item");

    // the frame start item is always the sync byte
    a_sync_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_position == tfdx_pkg::POS_SYNC
            |-> o_out_frame_byte == tfdx_pkg::SYNC_BYTE
                && o_out_frame_status == tfdx_pkg::ST_BUSY)
        else $error("position zero item is not a sync byte");

endmodule

bind typed_frame_deframer_xor_unit tfdx_checker u_tfdx_checker (.*);

`default_nettype wire

// File: test/typed_frame_deframer_xor_unit_tb.sv
// testbench for the typed frame deframer with xor checksum, checked against a built-in predictor
`timescale 1ns / 1ps

module typed_frame_deframer_xor_unit_tb;
    import tfdx_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_in_kind;
    logic [7:0]  i_in_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_frame_byte;
    logic [5:0]  o_out_position;
    logic        o_out_last;
    logic [2:0]  o_out_frame_status;

    typed_frame_deframer_xor_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_kind          (i_in_kind),
        .i_in_rx_byte       (i_in_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_frame_byte   (o_out_frame_byte),
        .o_out_position     (o_out_position),
        .o_out_last         (o_out_last),
        .o_out_frame_status (o_out_frame_status)
    );

    t_phase      frm_phase;
    logic [5:0]  frm_index;
    logic [5:0]  frm_length;
    logic [7:0]  frm_xor;
    logic [15:0] frm_ticks;
    logic [15:0] frm_limit;

    t_result expected_results[$];
    int      errors = 0;
    int      items_sent = 0;
    bit      calm = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 22);
    end

    function automatic void frm_restart();
        frm_phase  = PH_HUNT;
        frm_index  = 6'd0;
        frm_length = 6'd0;
        frm_xor    = 8'd0;
        frm_ticks  = 16'd0;
    endfunction

    function automatic bit deframe_step(input logic kind, input logic [7:0] data,
                                        output t_result r);
        logic [16:0] next_ticks;
        logic [5:0]  len;
        r = '0;
        if (kind == KIND_TICK) begin
            if (frm_phase != PH_TYPE && frm_phase != PH_DATA) begin
                return 1'b0;
            end
            next_ticks = {1'b0, frm_ticks} + 17'd1;
            if (next_ticks > {1'b0, frm_limit}) begin
                r.frame_byte   = 8'd0;
                r.position     = frm_index;
                r.last         = 1'b1;
                r.frame_status = ST_TIMEOUT;
                frm_restart();
                return 1'b1;
            end
            frm_ticks = next_ticks[15:0];
            return 1'b0;
        end
        r.frame_byte = data;
        if (frm_phase == PH_TYPE) begin
            case (data)
                TYPE_LONG:  len = LEN_LONG;
                TYPE_MID:   len = LEN_MID;
                TYPE_SHORT: len = LEN_SHORT;
                default:    len = LEN_NONE;
            endcase
            r.position = POS_TYPE;
            if (len == LEN_NONE) begin
                r.last         = 1'b1;
                r.frame_status = ST_BADTYPE;
                frm_restart();
                return 1'b1;
            end
            r.last         = 1'b0;
            r.frame_status = ST_BUSY;
            frm_length     = len;
            frm_xor        = frm_xor ^ data;
            frm_index      = POS_FIRST_DAT;
            frm_phase      = PH_DATA;
            return 1'b1;
        end
        if (frm_phase == PH_DATA) begin
            r.position = frm_index;
            if ({1'b0, frm_index} + 7'd1 >= {1'b0, frm_length}) begin
                r.last         = 1'b1;
                r.frame_status = (frm_xor == data) ? ST_GOOD : ST_BADSUM;
                frm_restart();
                return 1'b1;
            end
            r.last         = 1'b0;
            r.frame_status = ST_BUSY;
            frm_xor        = frm_xor ^ data;
            frm_index      = frm_index + 6'd1;
            return 1'b1;
        end
        if (data != SYNC_BYTE) begin
            frm_phase = PH_HUNT;
            return 1'b0;
        end
        r.position     = POS_SYNC;
        r.last         = 1'b0;
        r.frame_status = ST_BUSY;
        frm_phase      = PH_TYPE;
        frm_index      = POS_TYPE;
        frm_length     = LEN_NONE;
        frm_xor        = SYNC_BYTE;
        frm_ticks      = 16'd0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item, position", o_out_position, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_frame_byte !== want.frame_byte) begin
                    report_mismatch("frame_byte", o_out_frame_byte, want.frame_byte);
                end
                if (o_out_position !== want.position) begin
                    report_mismatch("position", o_out_position, want.position);
                end
                if (o_out_last !== want.last) begin
                    report_mismatch("last", o_out_last, want.last);
                end
                if (o_out_frame_status !== want.frame_status) begin
                    report_mismatch("frame_status", o_out_frame_status, want.frame_status);
                end
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data);
        t_result res;
        bit      has;
        if (!calm) begin
            while ($urandom_range(0, 99) < 22) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_in_kind    <= kind;
        i_in_rx_byte <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        has = deframe_step(kind, data, res);
        if (has) begin
            expected_results.push_back(res);
        end
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        frm_limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    // sends sync, type, data and checksum; cut_at stops early, sync_at forces a sync byte
    task automatic send_frame(input logic [7:0] type_byte, input bit good_sum,
                              input int tick_pct, input int cut_at, input int sync_at);
        int         full_len;
        int         count;
        logic [7:0] sum;
        logic [7:0] data;
        case (type_byte)
            TYPE_LONG:  full_len = LEN_LONG;
            TYPE_MID:   full_len = LEN_MID;
            TYPE_SHORT: full_len = LEN_SHORT;
            default:    full_len = 2;
        endcase
        count = (cut_at >= 0 && cut_at < full_len) ? cut_at : full_len;
        sum = 8'd0;
        for (int i = 0; i < count; i++) begin
            while ($urandom_range(0, 99) < tick_pct) begin
                send_item(KIND_TICK, $urandom_range(0, 255));
            end
            if (i == 0) begin
                data = SYNC_BYTE;
            end else if (i == 1) begin
                data = type_byte;
            end else if (i == full_len - 1) begin
                data = good_sum ? sum : (sum ^ $urandom_range(1, 255));
            end else if (i == sync_at || $urandom_range(0, 9) == 0) begin
                data = SYNC_BYTE;
            end else begin
                data = $urandom_range(0, 255);
            end
            sum = sum ^ data;
            send_item(KIND_BYTE, data);
        end
    endtask

    task automatic test_hunting_and_bad_type();
        send_item(KIND_TICK, 8'hFF);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_frame(8'hFF, 1'b1, 0, -1, -1);
        send_frame(8'h00, 1'b1, 0, -1, -1);
    endtask

    task automatic test_short_frame_with_sync_data();
        send_frame(TYPE_SHORT, 1'b1, 0, -1, 4);
    endtask

    task automatic test_timeout_edges();
        wait_idle();
        cfg_write(16'd0);
        send_frame(TYPE_LONG, 1'b1, 0, 1, -1);
        send_item(KIND_TICK, 8'h00);
        send_frame(TYPE_MID, 1'b1, 0, 2, -1);
        send_item(KIND_TICK, 8'hFF);
        wait_idle();
        cfg_write(16'd1);
        send_frame(TYPE_SHORT, 1'b1, 0, 3, -1);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'h00);
    endtask

    task automatic test_random_frames(input logic [15:0] limit, input int n_items,
                                      input bit quiet);
        int         stop;
        int         pick;
        logic [7:0] t;
        wait_idle();
        cfg_write(limit);
        calm = quiet;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       t = TYPE_LONG;
                1:       t = TYPE_MID;
                default: t = TYPE_SHORT;
            endcase
            if (pick < 70) begin
                send_frame(t, $urandom_range(0, 3) != 0, 4, -1, -1);
            end else if (pick < 80) begin
                send_frame($urandom_range(0, 255), 1'b1, 4, -1, -1);
            end else if (pick < 90) begin
                send_frame(t, 1'b1, 4, $urandom_range(1, 33), -1);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_item($urandom_range(0, 1), $urandom_range(0, 255));
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= 16'd0;
        i_in_valid   <= 1'b0;
        i_in_kind    <= KIND_BYTE;
        i_in_rx_byte <= 8'd0;
        i_out_stall  <= 1'b0;
        frm_restart();
        frm_limit = TIMEOUT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_hunting_and_bad_type();
        test_short_frame_with_sync_data();
        test_timeout_edges();
        test_random_frames(16'd2000, 300, 1'b0);
        test_random_frames(16'd0, 250, 1'b0);
        test_random_frames(16'hFFFF, 300, 1'b1);
        test_random_frames($urandom_range(1, 6), 300, 1'b0);
        test_random_frames($urandom_range(0, 65535), 300, 1'b0);
        wait_idle();
        if (errors == 0) begin
            $display("typed_frame_deframer_xor_unit_tb passed");
        end else begin
            $display("typed_frame_deframer_xor_unit_tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("typed_frame_deframer_xor_unit_tb failed");
        $finish;
    end

endmodule
